// File: rtl/core/epoch_seconds_to_calendar_macros.svh
// assertion macros shared by the calendar converter checkers
// clocked on aclk, reset on aresetn (active low)
`ifndef EPOCH_SECONDS_TO_CALENDAR_MACROS_SVH
`define EPOCH_SECONDS_TO_CALENDAR_MACROS_SVH

// property checked outside reset
`define ESC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// property checked on every edge, reset included
`define ESC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// File: rtl/core/esc_pkg.sv
// constants and types for the epoch seconds to calendar converter
// reciprocal multipliers, cumulative month-day table and stream field layout
`timescale 1ns / 1ps

package esc_pkg;

    // stream layout
    localparam int IN_W        = 39;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 48;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int HOUR_W  = 5;
    localparam int MIN_W   = 6;
    localparam int SEC_W   = 6;
    localparam int WDAY_W  = 3;

    localparam int YEAR_LSB  = 0;
    localparam int MONTH_LSB = YEAR_LSB + YEAR_W;
    localparam int DAY_LSB   = MONTH_LSB + MONTH_W;
    localparam int HOUR_LSB  = DAY_LSB + DAY_W;
    localparam int MIN_LSB   = HOUR_LSB + HOUR_W;
    localparam int SEC_LSB   = MIN_LSB + MIN_W;
    localparam int WDAY_LSB  = SEC_LSB + SEC_W;
    localparam int FIELDS_W  = WDAY_LSB + WDAY_W;

    localparam int NUM_STAGES = 9;

    // accepted span, 0001-01-01T00:00:00 through 9999-12-31T23:59:59
    localparam logic signed [IN_W-1:0] FIRST_SECOND  = -39'sd62135596800;
    localparam logic signed [IN_W-1:0] LAST_SECOND   = 39'sd253402300799;
    localparam logic        [IN_W-1:0] SECS_TO_EPOCH = 39'd62135596800;

    // internal widths
    localparam int DAYNUM_W = 22;   // days since 0001-01-01
    localparam int SOD_W    = 17;   // second of day
    localparam int R400_W   = 18;
    localparam int R100_W   = 16;
    localparam int R4_W     = 11;
    localparam int YDAY_W   = 9;
    localparam int REMH_W   = 12;   // second of hour
    localparam int Q400_W   = 5;
    localparam int Q100_W   = 2;
    localparam int Q4_W     = 5;
    localparam int Q1_W     = 2;
    localparam int Q7_W     = 20;

    // seconds per day = 2^7 * 675; the odd part goes through a reciprocal
    localparam int DAY_SHIFT   = 7;
    localparam int DAY_ODD     = 675;
    localparam int DAY_HI_W    = IN_W - DAY_SHIFT;
    localparam int DAY_REM_W   = 10;
    localparam int DAY_K       = 42;
    localparam int DAY_M_W     = 33;
    localparam logic [DAY_M_W-1:0] DAY_M =
        DAY_M_W'(((64'd1 << DAY_K) + 64'(DAY_ODD) - 64'd1) / 64'(DAY_ODD));

    localparam int DAYS_400Y = 146097;
    localparam int DAYS_100Y = 36524;
    localparam int DAYS_4Y   = 1461;
    localparam int DAYS_1Y   = 365;
    localparam int SECS_HOUR = 3600;
    localparam int SECS_MIN  = 60;
    localparam int WEEK_DAYS = 7;

    localparam int Y400_K   = 40;
    localparam int Y400_M_W = 23;
    localparam logic [Y400_M_W-1:0] Y400_M =
        Y400_M_W'(((64'd1 << Y400_K) + 64'(DAYS_400Y) - 64'd1) / 64'(DAYS_400Y));

    localparam int Y4_K   = 27;
    localparam int Y4_M_W = 17;
    localparam logic [Y4_M_W-1:0] Y4_M =
        Y4_M_W'(((64'd1 << Y4_K) + 64'(DAYS_4Y) - 64'd1) / 64'(DAYS_4Y));

    localparam int HOUR_K   = 29;
    localparam int HOUR_M_W = 18;
    localparam logic [HOUR_M_W-1:0] HOUR_M =
        HOUR_M_W'(((64'd1 << HOUR_K) + 64'(SECS_HOUR) - 64'd1) / 64'(SECS_HOUR));

    localparam int MIN_K   = 18;
    localparam int MIN_M_W = 13;
    localparam logic [MIN_M_W-1:0] MIN_M =
        MIN_M_W'(((64'd1 << MIN_K) + 64'(SECS_MIN) - 64'd1) / 64'(SECS_MIN));

    localparam int WEEK_K   = 25;
    localparam int WEEK_M_W = 23;
    localparam logic [WEEK_M_W-1:0] WEEK_M =
        WEEK_M_W'(((64'd1 << WEEK_K) + 64'(WEEK_DAYS) - 64'd1) / 64'(WEEK_DAYS));

    typedef logic [YDAY_W-1:0] yday_t;

    // cumulative days before each month, common row then leap row
    localparam yday_t CUM_DAYS [2][14] = '{
        '{9'd0, 9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
          9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365},
        '{9'd0, 9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
          9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335, 9'd366}
    };

endpackage

// File: rtl/core/epoch_seconds_to_calendar.sv
// epoch seconds to Gregorian calendar date, time of day and weekday (uses esc_pkg)
// throughput: one item per cycle unless m_tready stalls the output, through the nine-stage
// register pipeline of reciprocal multiplies and subtracts; a stage holds only while the next one is full
// reset: aresetn clears the stage valid bits only, payload registers are not reset
`timescale 1ns / 1ps

module epoch_seconds_to_calendar import esc_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // [38:0] epoch_seconds
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [13:0] year, [17:14] month, [22:18] day_of_month, [27:23] hour,
    // [33:28] minute, [39:34] second, [42:40] week_day
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tuser    // [0] out_of_range
);

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] stage_en;

    // per-stage advance, so bubbles fill while the output is stalled
    always_comb begin
        stage_en[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_tready;
        for (int i = NUM_STAGES - 2; i >= 0; i--) begin
            stage_en[i] = !valid_reg[i] || stage_en[i+1];
        end
        valid_next = {valid_reg[NUM_STAGES-2:0], s_tvalid};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            for (int i = 0; i < NUM_STAGES; i++) begin
                if (stage_en[i]) begin
                    valid_reg[i] <= valid_next[i];
                end
            end
        end
    end

    assign s_tready = stage_en[0];
    assign m_tvalid = valid_reg[NUM_STAGES-1];

    // stage 0: range check and shift to seconds since year 1
    logic signed [IN_W-1:0] epoch;
    logic                   s0_oor_next;
    logic [IN_W-1:0]        s0_total_next;
    logic                   s0_oor_reg;
    logic [IN_W-1:0]        s0_total_reg;

    always_comb begin
        epoch         = signed'(s_tdata[IN_W-1:0]);
        s0_oor_next   = (epoch < FIRST_SECOND) || (epoch > LAST_SECOND);
        s0_total_next = s_tdata[IN_W-1:0] + SECS_TO_EPOCH;
    end

    // stage 1: day quotient by reciprocal of the odd part of 86400
    logic                           s1_oor_reg;
    logic [DAY_HI_W-1:0]            s1_hi_reg;
    logic [DAY_SHIFT-1:0]           s1_low_reg;
    logic [DAY_HI_W+DAY_M_W-1:0]    s1_prod_reg;

    // stage 2: day number and second of day
    logic [DAYNUM_W-1:0] s2_n_next;
    logic [DAY_HI_W-1:0] s2_back;
    logic [DAY_HI_W-1:0] s2_rem;
    logic [SOD_W-1:0]    s2_sod_next;
    logic                s2_oor_reg;
    logic [DAYNUM_W-1:0] s2_n_reg;
    logic [SOD_W-1:0]    s2_sod_reg;

    always_comb begin
        s2_n_next   = s1_prod_reg[DAY_K +: DAYNUM_W];
        s2_back     = DAY_HI_W'(s2_n_next) * DAY_HI_W'(DAY_ODD);
        s2_rem      = s1_hi_reg - s2_back;
        s2_sod_next = {s2_rem[DAY_REM_W-1:0], s1_low_reg};
    end

    // stage 3: reciprocal products for 400-year block, hour and weekday
    logic                             s3_oor_reg;
    logic [DAYNUM_W-1:0]              s3_n_reg;
    logic [SOD_W-1:0]                 s3_sod_reg;
    logic [DAYNUM_W+Y400_M_W-1:0]     s3_p400_reg;
    logic [SOD_W+HOUR_M_W-1:0]        s3_phour_reg;
    logic [DAYNUM_W+WEEK_M_W-1:0]     s3_pweek_reg;
    logic [DAYNUM_W-1:0]              s3_n1_next;

    assign s3_n1_next = s2_n_reg + DAYNUM_W'(1);

    // stage 4: 400-year remainder, hour, second of hour, weekday
    logic [Q400_W-1:0]   s4_q400_next;
    logic [DAYNUM_W-1:0] s4_back400;
    logic [R400_W-1:0]   s4_r400_next;
    logic [HOUR_W-1:0]   s4_hour_next;
    logic [SOD_W-1:0]    s4_backh;
    logic [REMH_W-1:0]   s4_remh_next;
    logic [DAYNUM_W-1:0] s4_n1;
    logic [Q7_W-1:0]     s4_q7;
    logic [DAYNUM_W-1:0] s4_back7;
    logic [WDAY_W-1:0]   s4_wday_next;
    logic                s4_oor_reg;
    logic [Q400_W-1:0]   s4_q400_reg;
    logic [R400_W-1:0]   s4_r400_reg;
    logic [HOUR_W-1:0]   s4_hour_reg;
    logic [REMH_W-1:0]   s4_remh_reg;
    logic [WDAY_W-1:0]   s4_wday_reg;

    always_comb begin
        s4_q400_next = s3_p400_reg[Y400_K +: Q400_W];
        s4_back400   = DAYNUM_W'(32'(s4_q400_next) * 32'(DAYS_400Y));
        s4_r400_next = R400_W'(s3_n_reg - s4_back400);
        s4_hour_next = s3_phour_reg[HOUR_K +: HOUR_W];
        s4_backh     = SOD_W'(32'(s4_hour_next) * 32'(SECS_HOUR));
        s4_remh_next = REMH_W'(s3_sod_reg - s4_backh);
        // 0001-01-01 was a monday, so day n + 1 counts from a sunday
        s4_n1        = s3_n_reg + DAYNUM_W'(1);
        s4_q7        = s3_pweek_reg[WEEK_K +: Q7_W];
        s4_back7     = DAYNUM_W'(32'(s4_q7) * 32'(WEEK_DAYS));
        s4_wday_next = WDAY_W'(s4_n1 - s4_back7);
    end

    // stage 5: century within the 400-year block, minute product
    logic [Q100_W-1:0]          s5_q100_next;
    logic [R400_W-1:0]          s5_back100;
    logic [R100_W-1:0]          s5_r100_next;
    logic                       s5_oor_reg;
    logic [Q400_W-1:0]          s5_q400_reg;
    logic [Q100_W-1:0]          s5_q100_reg;
    logic [R100_W-1:0]          s5_r100_reg;
    logic [HOUR_W-1:0]          s5_hour_reg;
    logic [REMH_W-1:0]          s5_remh_reg;
    logic [REMH_W+MIN_M_W-1:0]  s5_pmin_reg;
    logic [WDAY_W-1:0]          s5_wday_reg;

    always_comb begin
        // the last century of a block keeps its extra day
        if (s4_r400_reg >= R400_W'(3 * DAYS_100Y)) begin
            s5_q100_next = Q100_W'(3);
        end else if (s4_r400_reg >= R400_W'(2 * DAYS_100Y)) begin
            s5_q100_next = Q100_W'(2);
        end else if (s4_r400_reg >= R400_W'(DAYS_100Y)) begin
            s5_q100_next = Q100_W'(1);
        end else begin
            s5_q100_next = Q100_W'(0);
        end
        s5_back100   = R400_W'(32'(s5_q100_next) * 32'(DAYS_100Y));
        s5_r100_next = R100_W'(s4_r400_reg - s5_back100);
    end

    // stage 6: 4-year product, minute and second
    logic [MIN_W-1:0]           s6_min_next;
    logic [REMH_W-1:0]          s6_backm;
    logic [SEC_W-1:0]           s6_sec_next;
    logic                       s6_oor_reg;
    logic [Q400_W-1:0]          s6_q400_reg;
    logic [Q100_W-1:0]          s6_q100_reg;
    logic [R100_W-1:0]          s6_r100_reg;
    logic [R100_W+Y4_M_W-1:0]   s6_p4_reg;
    logic [HOUR_W-1:0]          s6_hour_reg;
    logic [MIN_W-1:0]           s6_min_reg;
    logic [SEC_W-1:0]           s6_sec_reg;
    logic [WDAY_W-1:0]          s6_wday_reg;

    always_comb begin
        s6_min_next = s5_pmin_reg[MIN_K +: MIN_W];
        s6_backm    = REMH_W'(32'(s6_min_next) * 32'(SECS_MIN));
        s6_sec_next = SEC_W'(s5_remh_reg - s6_backm);
    end

    // stage 7: 4-year block, year within it, day of year, leap flag
    logic [Q4_W-1:0]   s7_q4;
    logic [R100_W-1:0] s7_back4;
    logic [R4_W-1:0]   s7_r4;
    logic [Q1_W-1:0]   s7_q1;
    logic [R4_W-1:0]   s7_back1;
    logic [YDAY_W-1:0] s7_yday_next;
    logic [YEAR_W-1:0] s7_year_next;
    logic              s7_leap_next;
    logic              s7_oor_reg;
    logic [YEAR_W-1:0] s7_year_reg;
    logic [YDAY_W-1:0] s7_yday_reg;
    logic              s7_leap_reg;
    logic [HOUR_W-1:0] s7_hour_reg;
    logic [MIN_W-1:0]  s7_min_reg;
    logic [SEC_W-1:0]  s7_sec_reg;
    logic [WDAY_W-1:0] s7_wday_reg;

    always_comb begin
        s7_q4    = s6_p4_reg[Y4_K +: Q4_W];
        s7_back4 = R100_W'(32'(s7_q4) * 32'(DAYS_4Y));
        s7_r4    = R4_W'(s6_r100_reg - s7_back4);
        if (s7_r4 >= R4_W'(3 * DAYS_1Y)) begin
            s7_q1 = Q1_W'(3);
        end else if (s7_r4 >= R4_W'(2 * DAYS_1Y)) begin
            s7_q1 = Q1_W'(2);
        end else if (s7_r4 >= R4_W'(DAYS_1Y)) begin
            s7_q1 = Q1_W'(1);
        end else begin
            s7_q1 = Q1_W'(0);
        end
        s7_back1     = R4_W'(32'(s7_q1) * 32'(DAYS_1Y));
        s7_yday_next = YDAY_W'(s7_r4 - s7_back1);
        s7_year_next = YEAR_W'(32'(s6_q400_reg) * 32'd400 + 32'(s6_q100_reg) * 32'd100
                               + 32'(s7_q4) * 32'd4 + 32'(s7_q1) + 32'd1);
        // last year of a 4-year block, except century years not closing a 400-year block
        s7_leap_next = (s7_q1 == Q1_W'(3)) &&
                       ((s7_q4 != Q4_W'(24)) || (s6_q100_reg == Q100_W'(3)));
    end

    // stage 8: month and day from the cumulative table, output register
    logic [MONTH_W-1:0]  s8_month;
    yday_t               s8_base;
    logic [DAY_W-1:0]    s8_day;
    logic [FIELDS_W-1:0] s8_fields_next;
    logic                s8_oor_reg;
    logic [FIELDS_W-1:0] s8_fields_reg;

    always_comb begin
        s8_month = MONTH_W'(12);
        for (int i = 12; i >= 1; i--) begin
            if (s7_yday_reg < CUM_DAYS[s7_leap_reg][i+1]) begin
                s8_month = MONTH_W'(i);
            end
        end
        s8_base = CUM_DAYS[s7_leap_reg][s8_month];
        s8_day  = DAY_W'(s7_yday_reg - s8_base + YDAY_W'(1));
        if (s7_oor_reg) begin
            s8_fields_next = '0;
        end else begin
            s8_fields_next = {s7_wday_reg, s7_sec_reg, s7_min_reg, s7_hour_reg,
                              s8_day, s8_month, s7_year_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            s0_oor_reg   <= s0_oor_next;
            s0_total_reg <= s0_total_next;
        end
        if (stage_en[1]) begin
            s1_oor_reg  <= s0_oor_reg;
            s1_hi_reg   <= s0_total_reg[IN_W-1:DAY_SHIFT];
            s1_low_reg  <= s0_total_reg[DAY_SHIFT-1:0];
            s1_prod_reg <= (DAY_HI_W+DAY_M_W)'(s0_total_reg[IN_W-1:DAY_SHIFT]) *
                           (DAY_HI_W+DAY_M_W)'(DAY_M);
        end
        if (stage_en[2]) begin
            s2_oor_reg <= s1_oor_reg;
            s2_n_reg   <= s2_n_next;
            s2_sod_reg <= s2_sod_next;
        end
        if (stage_en[3]) begin
            s3_oor_reg   <= s2_oor_reg;
            s3_n_reg     <= s2_n_reg;
            s3_sod_reg   <= s2_sod_reg;
            s3_p400_reg  <= (DAYNUM_W+Y400_M_W)'(s2_n_reg) *
                            (DAYNUM_W+Y400_M_W)'(Y400_M);
            s3_phour_reg <= (SOD_W+HOUR_M_W)'(s2_sod_reg) *
                            (SOD_W+HOUR_M_W)'(HOUR_M);
            s3_pweek_reg <= (DAYNUM_W+WEEK_M_W)'(s3_n1_next) *
                            (DAYNUM_W+WEEK_M_W)'(WEEK_M);
        end
        if (stage_en[4]) begin
            s4_oor_reg  <= s3_oor_reg;
            s4_q400_reg <= s4_q400_next;
            s4_r400_reg <= s4_r400_next;
            s4_hour_reg <= s4_hour_next;
            s4_remh_reg <= s4_remh_next;
            s4_wday_reg <= s4_wday_next;
        end
        if (stage_en[5]) begin
            s5_oor_reg  <= s4_oor_reg;
            s5_q400_reg <= s4_q400_reg;
            s5_q100_reg <= s5_q100_next;
            s5_r100_reg <= s5_r100_next;
            s5_hour_reg <= s4_hour_reg;
            s5_remh_reg <= s4_remh_reg;
            s5_pmin_reg <= (REMH_W+MIN_M_W)'(s4_remh_reg) * (REMH_W+MIN_M_W)'(MIN_M);
            s5_wday_reg <= s4_wday_reg;
        end
        if (stage_en[6]) begin
            s6_oor_reg  <= s5_oor_reg;
            s6_q400_reg <= s5_q400_reg;
            s6_q100_reg <= s5_q100_reg;
            s6_r100_reg <= s5_r100_reg;
            s6_p4_reg   <= (R100_W+Y4_M_W)'(s5_r100_reg) * (R100_W+Y4_M_W)'(Y4_M);
            s6_hour_reg <= s5_hour_reg;
            s6_min_reg  <= s6_min_next;
            s6_sec_reg  <= s6_sec_next;
            s6_wday_reg <= s5_wday_reg;
        end
        if (stage_en[7]) begin
            s7_oor_reg  <= s6_oor_reg;
            s7_year_reg <= s7_year_next;
            s7_yday_reg <= s7_yday_next;
            s7_leap_reg <= s7_leap_next;
            s7_hour_reg <= s6_hour_reg;
            s7_min_reg  <= s6_min_reg;
            s7_sec_reg  <= s6_sec_reg;
            s7_wday_reg <= s6_wday_reg;
        end
        if (stage_en[8]) begin
            s8_oor_reg    <= s7_oor_reg;
            s8_fields_reg <= s8_fields_next;
        end
    end

    assign m_tdata = {(OUT_TDATA_W-FIELDS_W)'(0), s8_fields_reg};
    assign m_tuser = s8_oor_reg;

endmodule

// File: rtl/core/esc_checker.sv
// port-level checker for epoch_seconds_to_calendar, bound to the top level
// uses esc_pkg field offsets and the shared assertion macros
`timescale 1ns / 1ps
`include "epoch_seconds_to_calendar_macros.svh"

module esc_checker import esc_pkg::*; (
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic                   m_tuser
);

    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   mday;
    logic [HOUR_W-1:0]  hour;
    logic [MIN_W-1:0]   minute;
    logic [SEC_W-1:0]   second;
    logic [WDAY_W-1:0]  wday;
    logic [YEAR_W-1:0]  year;
    logic               fields_ok;

    always_comb begin
        year      = m_tdata[YEAR_LSB +: YEAR_W];
        month     = m_tdata[MONTH_LSB +: MONTH_W];
        mday      = m_tdata[DAY_LSB +: DAY_W];
        hour      = m_tdata[HOUR_LSB +: HOUR_W];
        minute    = m_tdata[MIN_LSB +: MIN_W];
        second    = m_tdata[SEC_LSB +: SEC_W];
        wday      = m_tdata[WDAY_LSB +: WDAY_W];
        fields_ok = (year != '0) && (month != '0) && (month <= MONTH_W'(12)) &&
                    (mday != '0) && (hour < HOUR_W'(24)) && (minute < MIN_W'(60)) &&
                    (second < SEC_W'(60)) && (wday < WDAY_W'(7));
    end

    `ESC_ASSERT_ALWAYS(a_reset_empties, !aresetn |=> !m_tvalid, "item shown right after reset")
    `ESC_ASSERT(a_valid_holds, m_tvalid && !m_tready |=> m_tvalid, "item dropped while stalled")
    `ESC_ASSERT(a_data_holds, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser), "item changed while stalled")
    `ESC_ASSERT(a_oor_zero, m_tvalid && m_tuser |-> m_tdata == '0, "out-of-range item carries fields")
    `ESC_ASSERT(a_fields_legal, m_tvalid && !m_tuser |-> fields_ok, "in-range item has an illegal field")

endmodule

bind epoch_seconds_to_calendar esc_checker u_esc_checker (.*);

// File: test/tb_top.sv
// self-checking bench for epoch_seconds_to_calendar: random stream traffic with stalls,
// an in-bench date predictor and an in-order scoreboard of expected calendar items
// depends on esc_pkg for port widths and output field positions
`timescale 1ns / 1ps

module tb_top;
    import esc_pkg::*;

    localparam longint EPOCH_OFFSET = 64'sd62135596800;   // 0001-01-01 to 1970-01-01
    localparam longint FINAL_SECOND = 64'sd253402300799;  // 9999-12-31T23:59:59
    localparam longint SPAN_SECONDS = FINAL_SECOND + EPOCH_OFFSET + 1;
    localparam int     IDLE_LIMIT   = 2000;

    // days before the first of each month, common row then leap row
    localparam int month_start [2][14] = '{
        '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365},
        '{0, 0, 31, 60, 91, 121, 152, 182, 213, 244, 274, 305, 335, 366}
    };

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   mday;
        logic [HOUR_W-1:0]  hour;
        logic [MIN_W-1:0]   minute;
        logic [SEC_W-1:0]   second;
        logic [WDAY_W-1:0]  wday;
        logic               out_of_range;
    } calendar_t;

    logic                   aclk     = 1'b0;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tuser;

    calendar_t pending_dates [$];
    int        mismatch_count = 0;
    int        idle_cycles    = 0;
    int        stall_left     = 0;
    bit        calm           = 1'b0;

    epoch_seconds_to_calendar u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic int is_leap(longint y);
        return ((y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0))) ? 1 : 0;
    endfunction

    // forward conversion from a civil date, independent of the predictor below
    function automatic longint epoch_of(longint y, int mo, int d, int hh, int mi, int ss);
        longint py;
        longint days;
        py   = y - 1;
        days = py * 365 + py / 4 - py / 100 + py / 400 + month_start[is_leap(y)][mo] + d - 1;
        return (days * 86400 + hh * 3600 + mi * 60 + ss) - EPOCH_OFFSET;
    endfunction

    function automatic calendar_t civil_from_epoch(logic signed [IN_W-1:0] secs);
        calendar_t c;
        longint    t, total, n, sod, r, q400, q100, q4, q1, yr;
        int        lp, mo;
        c = '0;
        t = longint'(secs);
        if (t < -EPOCH_OFFSET || t > FINAL_SECOND) begin
            c.out_of_range = 1'b1;
            return c;
        end
        total = t + EPOCH_OFFSET;
        n     = total / 86400;
        sod   = total % 86400;
        q400  = n / 146097;
        r     = n % 146097;
        q100  = r / 36524;
        // last day of a 400-year block and of a 4-year block would overflow
        if (q100 > 3) q100 = 3;
        r    -= q100 * 36524;
        q4    = r / 1461;
        r    -= q4 * 1461;
        q1    = r / 365;
        if (q1 > 3) q1 = 3;
        r    -= q1 * 365;
        yr    = q400 * 400 + q100 * 100 + q4 * 4 + q1 + 1;
        lp    = is_leap(yr);
        mo    = 1;
        while (mo < 12 && r >= month_start[lp][mo + 1]) mo++;
        c.year   = YEAR_W'(yr);
        c.month  = MONTH_W'(mo);
        c.mday   = DAY_W'(r - month_start[lp][mo] + 1);
        c.hour   = HOUR_W'(sod / 3600);
        c.minute = MIN_W'((sod % 3600) / 60);
        c.second = SEC_W'(sod % 60);
        c.wday   = WDAY_W'((n + 1) % 7);   // 0001-01-01 was a monday
        return c;
    endfunction

    function automatic logic signed [IN_W-1:0] pick_seconds();
        longint unsigned raw;
        longint          y;
        int              kind, mo, lp;
        raw  = {$urandom, $urandom};
        kind = $urandom_range(0, 9);
        if (kind < 5)
            return IN_W'(longint'(raw % SPAN_SECONDS) - EPOCH_OFFSET);
        if (kind < 8) begin
            // well-formed date, often near the 1904..2099 edges
            y  = ($urandom_range(0, 3) == 0) ? longint'($urandom_range(1895, 2110))
                                             : longint'($urandom_range(1, 9999));
            mo = $urandom_range(1, 12);
            lp = is_leap(y);
            return IN_W'(epoch_of(y, mo,
                $urandom_range(1, month_start[lp][mo + 1] - month_start[lp][mo]),
                $urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 59)));
        end
        return raw[IN_W-1:0];
    endfunction

    task automatic push_seconds(input logic signed [IN_W-1:0] secs);
        if (!calm && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_W - IN_W){1'b0}}, secs};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_dates.push_back(civil_from_epoch(secs));
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending_dates.size() != 0) @(posedge aclk);
    endtask

    task automatic test_span_edges();
        logic signed [IN_W-1:0] most_neg, most_pos;
        most_neg = {1'b1, {(IN_W - 1){1'b0}}};
        most_pos = {1'b0, {(IN_W - 1){1'b1}}};
        push_seconds(IN_W'(-EPOCH_OFFSET));
        push_seconds(IN_W'(FINAL_SECOND));
        push_seconds(IN_W'(-EPOCH_OFFSET - 1));
        push_seconds(IN_W'(FINAL_SECOND + 1));
        push_seconds(most_neg);
        push_seconds(most_pos);
    endtask

    task automatic test_calendar_corners();
        push_seconds('0);
        push_seconds(IN_W'(-1));
        push_seconds(IN_W'(-86400));
        push_seconds(IN_W'(epoch_of(2000, 2, 29, 12, 34, 56)));
        // last day of a 400-year block and of a leap 4-year block
        push_seconds(IN_W'(epoch_of(2000, 12, 31, 23, 59, 59)));
        push_seconds(IN_W'(epoch_of(1600, 12, 31, 0, 0, 0)));
        push_seconds(IN_W'(epoch_of(1996, 12, 31, 23, 59, 59)));
        push_seconds(IN_W'(epoch_of(1900, 2, 28, 23, 59, 59)));
        push_seconds(IN_W'(epoch_of(1900, 3, 1, 0, 0, 0)));
        push_seconds(IN_W'(epoch_of(2100, 3, 1, 0, 0, 0)));
        push_seconds(IN_W'(epoch_of(1903, 12, 31, 23, 59, 59)));
        push_seconds(IN_W'(epoch_of(1904, 1, 1, 0, 0, 0)));
        push_seconds(IN_W'(epoch_of(2099, 12, 31, 23, 59, 59)));
        push_seconds(IN_W'(epoch_of(2100, 1, 1, 0, 0, 0)));
        push_seconds(IN_W'(epoch_of(1, 12, 31, 12, 0, 0)));
        push_seconds(IN_W'(epoch_of(9999, 1, 1, 0, 0, 0)));
    endtask

    task automatic test_random_dates(input int count);
        repeat (count) push_seconds(pick_seconds());
    endtask

    task automatic test_drain_pause();
        test_random_dates(20);
        wait_drained();
        test_random_dates(20);
    endtask

    task automatic test_back_to_back(input int count);
        calm = 1'b1;
        test_random_dates(count);
    endtask

    // receiver stalls in short random bursts
    always @(posedge aclk) begin
        if (calm) begin
            m_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
            stall_left <= $urandom_range(0, 3);
            m_tready   <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge aclk) begin
        calendar_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_dates.size() == 0) begin
                $display("%0t unexpected calendar item: expected none actual tdata=%h tuser=%b",
                         $time, m_tdata, m_tuser);
                mismatch_count++;
            end else begin
                want = pending_dates.pop_front();
                check_field("year", longint'(want.year),
                            longint'(m_tdata[YEAR_LSB +: YEAR_W]));
                check_field("month", longint'(want.month),
                            longint'(m_tdata[MONTH_LSB +: MONTH_W]));
                check_field("day", longint'(want.mday),
                            longint'(m_tdata[DAY_LSB +: DAY_W]));
                check_field("hour", longint'(want.hour),
                            longint'(m_tdata[HOUR_LSB +: HOUR_W]));
                check_field("minute", longint'(want.minute),
                            longint'(m_tdata[MIN_LSB +: MIN_W]));
                check_field("second", longint'(want.second),
                            longint'(m_tdata[SEC_LSB +: SEC_W]));
                check_field("wday", longint'(want.wday),
                            longint'(m_tdata[WDAY_LSB +: WDAY_W]));
                check_field("out_of_range", longint'(want.out_of_range), longint'(m_tuser));
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_span_edges();
        test_calendar_corners();
        test_random_dates(430);
        test_drain_pause();
        test_random_dates(430);
        test_back_to_back(100);
        wait_drained();
        repeat (NUM_STAGES + 4) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
